// ----- rtl/ternary_block_to_tile_packer_assert.svh -----
// Assertion macros for the ternary block to tile packer.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef TERNARY_BLOCK_TO_TILE_PACKER_ASSERT_SVH
`define TERNARY_BLOCK_TO_TILE_PACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define TTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ttp_pkg.sv -----
// Shared types, constants and helper functions for the tile packer.
// No dependencies.
`default_nettype none

package ttp_pkg;

  // 2-bit quant codes
  localparam logic [1:0] CodeNeg  = 2'd0;
  localparam logic [1:0] CodeZero = 2'd1;
  localparam logic [1:0] CodePos  = 2'd2;
  localparam logic [1:0] CodeTwo  = 2'd3;

  localparam logic [7:0] ExpBias    = 8'd128;
  // frexp offsets: normal e-14+128, subnormal len-24+128
  localparam logic [7:0] ExpNormOfs = 8'd114;
  localparam logic [7:0] ExpSubOfs  = 8'd104;
  localparam logic [4:0] ExpAllOnes = 5'd31;

  localparam int unsigned TritsPerTile = 64;
  localparam int unsigned PackLanes    = 13;
  localparam int unsigned Subgroups    = 16;

  typedef logic [1:0] code_t;

  // Code to base-3 digit: -1 -> 2, 0 -> 0, +1 -> 1, +2 -> 0
  function automatic logic [1:0] code_digit(input code_t q);
    logic [1:0] d;
    unique case (q)
      CodeNeg:  d = 2'd2;
      CodeZero: d = 2'd0;
      CodePos:  d = 2'd1;
      CodeTwo:  d = 2'd0;
      default:  d = 2'd0;
    endcase
    return d;
  endfunction

  // Group of four holds at most one nonzero trit (+2 counts as nonzero)
  function automatic logic sparse4(input logic [3:0][1:0] q);
    logic [2:0] n;
    n = 3'(q[0] != CodeZero) + 3'(q[1] != CodeZero)
      + 3'(q[2] != CodeZero) + 3'(q[3] != CodeZero);
    return (n <= 3'd1);
  endfunction

  // Biased frexp exponent of a half-precision value
  function automatic logic [7:0] exp_biased(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] len;
    logic [7:0] x;
    e   = h[14:10];
    m   = h[9:0];
    len = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) len = 4'(i + 1);
    end
    if (e == ExpAllOnes) begin
      x = ExpBias;
    end else if (e == 5'd0) begin
      x = (m == 10'd0) ? ExpBias : (8'(len) + ExpSubOfs);
    end else begin
      x = 8'(e) + ExpNormOfs;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ternary_block_to_tile_packer.sv -----
// Ternary block to tile packer: usage notes
// Input channel (in_valid/in_ready): one 8-byte chunk of a 256-weight block
//   per item, with the block's fp16 scale and a final-chunk marker.
// Output channel (out_valid/out_ready): one 64-trit tile per item.
// Chunks 0..2 and 4..6 of a block are buffered and give no result. Chunk 3
//   and chunk 7 each complete a half block and give two tiles; tile 0 of the
//   pair goes via the job register to the output register, tile 1 after it.
// A final chunk anywhere but position 7 gives one error item (status 1, all
//   else zero) via job and output registers; the next chunk opens a block.
// Throughput with out_ready high: one chunk per cycle sustained; the output
//   register sends one tile a cycle; a four-chunk half block needs two slots.
// A half-block job register sits between the two sides, so chunks keep
//   arriving while the receiver holds off; in_ready falls only when the job
//   register is still busy and the next chunk would need it.
// Reset clears the chunk position and the job and output valid flags.
// Depends on ttp_pkg, ttp_tile, ttp_pack and the assertion macro header.
`default_nettype none

module ternary_block_to_tile_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_qs_chunk,
  input  wire logic [15:0] in_scale_half,
  input  wire logic        in_final_chunk,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_tile_pos,
  output logic [63:0]      out_trits_low,
  output logic [31:0]      out_trits_high,
  output logic [6:0]       out_trits_tail,
  output logic [7:0]       out_exponent_biased,
  output logic [15:0]      out_subgroup_flags,
  output logic             out_last_tile,
  output logic             out_status
);

  // chunk position and half-block buffer
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0][63:0]  buf_r;

  // job register: one completed half block or one error
  logic              job_valid_r, job_valid_nxt;
  logic              job_sel_r, job_sel_nxt;
  logic              job_err_r;
  logic              job_half_r;
  logic              job_fin_r;
  logic [7:0]        job_exp_r;
  logic [255:0]      job_bits_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_pos_r;
  logic [63:0]       out_low_r;
  logic [31:0]       out_high_r;
  logic [6:0]        out_tail_r;
  logic [7:0]        out_exp_r;
  logic [15:0]       out_flags_r;
  logic              out_last_r;
  logic              out_status_r;

  logic              in_fire, mid_end, half_done, make_job;
  logic              out_load, job_done;
  logic [63:0]       tile_low;
  logic [31:0]       tile_high;
  logic [6:0]        tile_tail;
  logic [15:0]       tile_flags;

  // handshake and control decode
  assign out_load  = !out_valid_r || out_ready;
  assign job_done  = job_valid_r && out_load && (job_err_r || job_sel_r);
  assign in_ready  = !job_valid_r || job_done || !(mid_end || half_done);
  assign in_fire   = in_valid && in_ready;
  assign mid_end   = in_final_chunk && (cnt_r != 3'd7);
  assign half_done = (cnt_r[1:0] == 2'd3);
  assign make_job  = in_fire && (mid_end || half_done);

  // next-state for control registers
  always_comb begin
    cnt_nxt       = cnt_r;
    job_valid_nxt = job_valid_r;
    job_sel_nxt   = job_sel_r;
    if (in_fire) begin
      cnt_nxt = mid_end ? 3'd0 : (cnt_r + 3'd1);
    end
    if (make_job) begin
      job_valid_nxt = 1'b1;
      job_sel_nxt   = 1'b0;
    end else if (job_done) begin
      job_valid_nxt = 1'b0;
    end else if (job_valid_r && out_load) begin
      job_sel_nxt = 1'b1;
    end
    out_valid_nxt = out_load ? job_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      job_valid_r <= 1'b0;
      job_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      job_valid_r <= job_valid_nxt;
      job_sel_r   <= job_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // chunk buffer and job payload
  always_ff @(posedge clk) begin
    if (in_fire && !mid_end && !half_done) begin
      buf_r[cnt_r[1:0]] <= in_qs_chunk;
    end
    if (make_job) begin
      job_err_r  <= mid_end;
      job_half_r <= cnt_r[2];
      job_fin_r  <= in_final_chunk;
      job_exp_r  <= ttp_pkg::exp_biased(in_scale_half);
      job_bits_r <= {in_qs_chunk, buf_r[2], buf_r[1], buf_r[0]};
    end
  end

  // tile lanes and merge
  ttp_tile u_tile (
    .half_bits  (job_bits_r),
    .tile_sel   (job_sel_r),
    .trits_low  (tile_low),
    .trits_high (tile_high),
    .trits_tail (tile_tail),
    .flags      (tile_flags)
  );

  // output register payload; error items carry zeros
  always_ff @(posedge clk) begin
    if (out_load && job_valid_r) begin
      if (job_err_r) begin
        out_pos_r    <= 2'd0;
        out_low_r    <= 64'd0;
        out_high_r   <= 32'd0;
        out_tail_r   <= 7'd0;
        out_exp_r    <= 8'd0;
        out_flags_r  <= 16'd0;
        out_last_r   <= 1'b0;
        out_status_r <= 1'b1;
      end else begin
        out_pos_r    <= {job_half_r, job_sel_r};
        out_low_r    <= tile_low;
        out_high_r   <= tile_high;
        out_tail_r   <= tile_tail;
        out_exp_r    <= job_exp_r;
        out_flags_r  <= tile_flags;
        out_last_r   <= job_fin_r && job_sel_r;
        out_status_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tile_pos        = out_pos_r;
  assign out_trits_low       = out_low_r;
  assign out_trits_high      = out_high_r;
  assign out_trits_tail      = out_tail_r;
  assign out_exponent_biased = out_exp_r;
  assign out_subgroup_flags  = out_flags_r;
  assign out_last_tile       = out_last_r;
  assign out_status          = out_status_r;

  // checks
`include "ternary_block_to_tile_packer_assert.svh"

  `TTP_ASSERT_NOW(a_err_zero, out_valid_r && out_status_r, (out_pos_r == 2'd0) && !out_last_r, "error item carries tile fields")
  `TTP_ASSERT_NOW(a_last_pos, out_valid_r && out_last_r, out_pos_r == 2'd3, "last tile flag off tile 3")
  `TTP_ASSERT_NEXT(a_final_rst, in_fire && in_final_chunk, cnt_r == 3'd0, "position not cleared after final chunk")
  `TTP_ASSERT_NOW(a_tail_rng, out_valid_r, out_tail_r <= 7'd80, "tail digit out of range")
  `TTP_ASSERT_NOW(a_no_clobber, make_job, !job_valid_r || job_done, "job overwritten before sent")

endmodule

`default_nettype wire

// ----- rtl/ttp_pack.sv -----
// One packing lane: five 2-bit codes into one base-3 byte.
// Depends on ttp_pkg.
`default_nettype none

module ttp_pack (
  input  wire logic [4:0][1:0] codes,
  output logic [7:0]           digits
);

  logic [4:0][1:0] d;

  // map codes to digits, then weigh by powers of three
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      d[k] = ttp_pkg::code_digit(codes[k]);
    end
    digits = 8'(d[0]) + 8'(d[1]) * 8'd3 + 8'(d[2]) * 8'd9
           + 8'(d[3]) * 8'd27 + 8'(d[4]) * 8'd81;
  end

endmodule

`default_nettype wire

// ----- rtl/ttp_tile.sv -----
// Tile builder: selects 64 trits of a half block, runs the packing lanes
// and the subgroup flag checks, and merges them into one tile. Uses ttp_pack.
`default_nettype none

module ttp_tile (
  input  wire logic [255:0] half_bits,
  input  wire logic         tile_sel,
  output logic [63:0]       trits_low,
  output logic [31:0]       trits_high,
  output logic [6:0]        trits_tail,
  output logic [15:0]       flags
);

  logic [63:0][1:0] codes;
  logic [12:0][7:0] lane_byte;

  genvar i, b, g;

  // trit i is bit pair (2*sel + i/32) of half byte i%32
  generate
    for (i = 0; i < 64; i++) begin : g_code
      localparam int M = i % 32;
      localparam int H = i / 32;
      assign codes[i] = tile_sel ? half_bits[8*M + 2*(2+H) +: 2]
                                 : half_bits[8*M + 2*H +: 2];
    end
  endgenerate

  // twelve five-trit lanes
  generate
    for (b = 0; b < 12; b++) begin : g_lane
      ttp_pack u_pack (
        .codes  (codes[5*b+4 : 5*b]),
        .digits (lane_byte[b])
      );
    end
  endgenerate

  // tail lane: four trits, fifth slot padded with a zero trit
  ttp_pack u_pack_tail (
    .codes  ({ttp_pkg::CodeZero, codes[63:60]}),
    .digits (lane_byte[12])
  );

  // subgroup flags
  generate
    for (g = 0; g < 16; g++) begin : g_flag
      assign flags[g] = ttp_pkg::sparse4(codes[4*g+3 : 4*g]);
    end
  endgenerate

  // merge lane bytes
  assign trits_low  = {lane_byte[7], lane_byte[6], lane_byte[5], lane_byte[4],
                       lane_byte[3], lane_byte[2], lane_byte[1], lane_byte[0]};
  assign trits_high = {lane_byte[11], lane_byte[10], lane_byte[9], lane_byte[8]};
  assign trits_tail = lane_byte[12][6:0];

endmodule

`default_nettype wire
